### design/cpenc_pkg.sv
// cpenc_pkg: shared types and constants of the code point encoder
// used by cpenc_front, cpenc_fifo, cpenc_back and the top level
`default_nettype none

package cpenc_pkg;

    localparam int FIFO_DEPTH = 2;
    localparam int UNITS_MAX  = 4;

    localparam logic [31:0] MAX_CODE_POINT   = 32'h0010_FFFF;
    localparam logic [20:0] REPLACEMENT_CHAR = 21'h00_FFFD;
    localparam logic [20:0] PLANE1_BASE      = 21'h01_0000;
    localparam logic [15:0] SURR_LOW         = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
    localparam logic [20:0] SURR_TOP_BITS    = 21'h00_001B;
    localparam logic [7:0]  CONT_MARK        = 8'h80;
    localparam logic [7:0]  LEAD2            = 8'hC0;
    localparam logic [7:0]  LEAD3            = 8'hE0;
    localparam logic [7:0]  LEAD4            = 8'hF0;

    typedef enum logic [1:0] {
        REG_OUTPUT_FORMAT = 2'd0,
        REG_STRICT_MODE   = 2'd1
    } cpenc_reg_idx_t;

    localparam logic FMT_UTF8  = 1'b0;
    localparam logic FMT_UTF16 = 1'b1;

    typedef struct packed {
        logic output_format;
        logic strict_mode;
    } cpenc_cfg_t;

    // one classified item: all units precomputed, index of the final one
    typedef struct packed {
        logic [UNITS_MAX-1:0][15:0] units;
        logic [1:0]                 last_idx;
        logic                       err;
    } cpenc_item_t;

endpackage

`default_nettype wire

### design/cpenc_front.sv
// cpenc_front: accepts code points, validates them and builds the unit list
// depends on cpenc_pkg
`default_nettype none

module cpenc_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cpenc_pkg::cpenc_cfg_t  cfg,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [31:0]            code_point,
    output logic                        fr_valid,
    input  wire logic                   fr_ready,
    output cpenc_pkg::cpenc_item_t      fr_item
);
    import cpenc_pkg::*;

    logic        fr_valid_reg;
    logic        fr_valid_next;
    cpenc_item_t fr_item_reg;
    cpenc_item_t enc;

    logic        big;
    logic        surr;
    logic        bad;
    logic [20:0] cc;
    logic [20:0] d;

    always_comb
    begin
        big  = code_point > MAX_CODE_POINT;
        surr = code_point[31:11] == SURR_TOP_BITS;
        bad  = big || (cfg.output_format == FMT_UTF16 && surr);
        cc   = bad ? REPLACEMENT_CHAR : code_point[20:0];
        d    = cc - PLANE1_BASE;
        enc  = '0;
        if (bad && cfg.strict_mode)
        begin
            enc.err      = 1'b1;
            enc.last_idx = 2'd0;
        end
        else if (cfg.output_format == FMT_UTF16)
        begin
            if (cc < PLANE1_BASE)
            begin
                enc.units[0] = cc[15:0];
                enc.last_idx = 2'd0;
            end
            else
            begin
                enc.units[0] = SURR_LOW + {6'd0, d[19:10]};
                enc.units[1] = LOW_SURR_BASE + {6'd0, d[9:0]};
                enc.last_idx = 2'd1;
            end
        end
        else
        begin
            if (cc < 21'h80)
            begin
                enc.units[0] = {9'd0, cc[6:0]};
                enc.last_idx = 2'd0;
            end
            else if (cc < 21'h800)
            begin
                enc.units[0] = {8'd0, LEAD2 | {3'd0, cc[10:6]}};
                enc.units[1] = {8'd0, CONT_MARK | {2'd0, cc[5:0]}};
                enc.last_idx = 2'd1;
            end
            else if (cc < PLANE1_BASE)
            begin
                enc.units[0] = {8'd0, LEAD3 | {4'd0, cc[15:12]}};
                enc.units[1] = {8'd0, CONT_MARK | {2'd0, cc[11:6]}};
                enc.units[2] = {8'd0, CONT_MARK | {2'd0, cc[5:0]}};
                enc.last_idx = 2'd2;
            end
            else
            begin
                enc.units[0] = {8'd0, LEAD4 | {5'd0, cc[20:18]}};
                enc.units[1] = {8'd0, CONT_MARK | {2'd0, cc[17:12]}};
                enc.units[2] = {8'd0, CONT_MARK | {2'd0, cc[11:6]}};
                enc.units[3] = {8'd0, CONT_MARK | {2'd0, cc[5:0]}};
                enc.last_idx = 2'd3;
            end
        end
    end

    assign in_ready = !fr_valid_reg || fr_ready;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (in_ready)
        begin
            fr_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fr_item_reg <= enc;
        end
    end

    assign fr_valid = fr_valid_reg;
    assign fr_item  = fr_item_reg;

endmodule

`default_nettype wire

### design/cpenc_fifo.sv
// cpenc_fifo: short item queue between the classifying front and the back
// depends on cpenc_pkg
`default_nettype none

module cpenc_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push_valid,
    output logic                        push_ready,
    input  wire cpenc_pkg::cpenc_item_t push_item,
    output logic                        pop_valid,
    input  wire logic                   pop_ready,
    output cpenc_pkg::cpenc_item_t      pop_item
);
    import cpenc_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cpenc_item_t          entries [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = count_reg != CNT_W'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("fifo count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fifo count not advanced on push");
`endif

endmodule

`default_nettype wire

### design/cpenc_back.sv
// cpenc_back: steps through the units of each queued item, one per cycle while the
// receiver takes them; depends on cpenc_pkg; drives the registered result channel
`default_nettype none

module cpenc_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    output logic                        q_ready,
    input  wire cpenc_pkg::cpenc_item_t q_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [15:0]                 unit,
    output logic                        last,
    output logic                        error
);
    import cpenc_pkg::*;

    cpenc_item_t item_reg;
    logic        busy_reg;
    logic        busy_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] unit_reg;
    logic        last_reg;
    logic        error_reg;

    cpenc_item_t cur;
    logic [1:0]  cur_idx;
    logic        slot_free;
    logic        emit;
    logic        is_last;
    logic        load;

    // a busy item is finished first; otherwise the queue head goes straight out
    always_comb
    begin
        cur       = busy_reg ? item_reg : q_item;
        cur_idx   = busy_reg ? idx_reg : 2'd0;
        slot_free = !out_valid_reg || out_ready;
        emit      = slot_free && (busy_reg || q_valid);
        is_last   = cur_idx == cur.last_idx;
        q_ready   = slot_free && !busy_reg;
        load      = emit && !busy_reg && !is_last;

        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (slot_free)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
                idx_next  = cur_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= q_item;
        end
        if (emit)
        begin
            unit_reg  <= cur.units[cur_idx];
            last_reg  <= is_last;
            error_reg <= cur.err;
        end
    end

    assign out_valid = out_valid_reg;
    assign unit      = unit_reg;
    assign last      = last_reg;
    assign error     = error_reg;

`ifndef SYNTHESIS
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && error_reg) |-> (last_reg && unit_reg == 16'h0000))
        else $error("error item is not a single zero unit");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg != 2'd0 && idx_reg <= item_reg.last_idx))
        else $error("unit index outside the busy item");
`endif

endmodule

`default_nettype wire

### design/codepoint_to_utf8_utf16_encoder.sv
// codepoint_to_utf8_utf16_encoder: top level, configuration registers
// depends on cpenc_pkg, cpenc_front, cpenc_fifo, cpenc_back
//
// Usage:
//   in channel  (in_valid/in_ready, code_point): one 32-bit code point per item.
//   out channel (out_valid/out_ready, unit, last, error): one UTF-8 byte (bits
//   7..0) or UTF-16 unit per item; last marks the final unit of a code point,
//   error marks the single zero unit given for a rejected value in strict mode.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 selects the
//   output format (0 UTF-8, 1 UTF-16), index 1 strict mode; other indexes are
//   ignored. cfg_ready is always high; write only while the block is idle.
// Path: a code point is registered in the front register, then written into
//   the queue; its first unit is then registered in the output register.
// Throughput: one unit per cycle while the receiver takes them; a code point
//   gives 1 to 4 units, which the back end steps through.
// Reset: format UTF-8, replace mode, all queued items dropped.
// A stalled receiver holds the output register; the two-entry queue and the
//   front register keep taking code points until they are full.
`default_nettype none

module codepoint_to_utf8_utf16_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] code_point,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      unit,
    output logic             last,
    output logic             error,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic        cfg_data
);
    import cpenc_pkg::*;

    cpenc_cfg_t  cfg_reg;
    cpenc_cfg_t  cfg_next;
    logic        fr_valid;
    logic        fr_ready;
    cpenc_item_t fr_item;
    logic        q_valid;
    logic        q_ready;
    cpenc_item_t q_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_OUTPUT_FORMAT: cfg_next.output_format = cfg_data;
                REG_STRICT_MODE:   cfg_next.strict_mode   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cpenc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_point (code_point),
        .fr_valid   (fr_valid),
        .fr_ready   (fr_ready),
        .fr_item    (fr_item)
    );

    cpenc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    cpenc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .unit       (unit),
        .last       (last),
        .error      (error)
    );

endmodule

`default_nettype wire

### bench/codepoint_to_utf8_utf16_encoder_test.sv
// codepoint_to_utf8_utf16_encoder_test: self-checking bench for the code point encoder
// predicts the UTF-8 / UTF-16 units of every accepted code point and checks them in order
// depends on cpenc_pkg and codepoint_to_utf8_utf16_encoder
`timescale 1ns / 100ps

module codepoint_to_utf8_utf16_encoder_test;

    import cpenc_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          PHASE_ITEMS  = 55;
    localparam int          RAND_PHASES  = 8;
    localparam logic [31:0] SURR_LAST    = 32'h0000_DFFF;
    // indexes past the two registers, writes there must be ignored
    localparam logic [1:0]  REG_SPARE_A  = 2'd2;
    localparam logic [1:0]  REG_SPARE_B  = 2'd3;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
        logic        err;
    } enc_unit_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] code_point;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] unit;
    logic        last;
    logic        error;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic        cfg_data;

    logic [31:0] pending_code_points [$];
    logic [31:0] edge_points [$];
    enc_unit_t   expected_units [$];

    logic fmt_model;
    logic strict_model;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic recv_hold;
    logic pressure_go;

    int mismatch_count;
    int accepted_count;
    int units_checked;
    int invalid_count;
    int input_stalls;
    int cycle_count;

    codepoint_to_utf8_utf16_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_point (code_point),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .unit       (unit),
        .last       (last),
        .error      (error),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // work out the units one code point turns into under the current settings
    function automatic void encode_code_point(input logic [31:0] cp);
        logic        bad;
        logic [20:0] c;
        logic [19:0] d;
        logic [7:0]  b [4];
        int          n;
        bad = (cp > MAX_CODE_POINT) ||
              (fmt_model == FMT_UTF16 && cp >= {16'h0000, SURR_LOW} && cp <= SURR_LAST);
        if (bad)
            invalid_count++;
        if (bad && strict_model)
        begin
            expected_units.push_back('{unit: 16'h0000, last: 1'b1, err: 1'b1});
            return;
        end
        c = bad ? REPLACEMENT_CHAR : cp[20:0];
        if (fmt_model == FMT_UTF16)
        begin
            if (c < PLANE1_BASE)
                expected_units.push_back('{unit: c[15:0], last: 1'b1, err: 1'b0});
            else
            begin
                d = 20'(c - PLANE1_BASE);
                expected_units.push_back('{unit: SURR_LOW + {6'h00, d[19:10]},
                                           last: 1'b0, err: 1'b0});
                expected_units.push_back('{unit: LOW_SURR_BASE + {6'h00, d[9:0]},
                                           last: 1'b1, err: 1'b0});
            end
        end
        else
        begin
            if (c < 21'h00_0080)
            begin
                b[0] = {1'b0, c[6:0]};
                n = 1;
            end
            else if (c < 21'h00_0800)
            begin
                b[0] = LEAD2 | {3'b000, c[10:6]};
                b[1] = CONT_MARK | {2'b00, c[5:0]};
                n = 2;
            end
            else if (c < PLANE1_BASE)
            begin
                b[0] = LEAD3 | {4'h0, c[15:12]};
                b[1] = CONT_MARK | {2'b00, c[11:6]};
                b[2] = CONT_MARK | {2'b00, c[5:0]};
                n = 3;
            end
            else
            begin
                b[0] = LEAD4 | {5'h00, c[20:18]};
                b[1] = CONT_MARK | {2'b00, c[17:12]};
                b[2] = CONT_MARK | {2'b00, c[11:6]};
                b[3] = CONT_MARK | {2'b00, c[5:0]};
                n = 4;
            end
            for (int i = 0; i < n; i++)
                expected_units.push_back('{unit: {8'h00, b[i]}, last: (i == n - 1),
                                           err: 1'b0});
        end
    endfunction

    // mostly valid code points spread over every encoding length, plus junk
    function automatic logic [31:0] random_code_point();
        logic [31:0] base;
        case ($urandom_range(9))
            0: return $urandom_range(32'h7F);
            1: return $urandom_range(32'h7FF, 32'h80);
            2: return $urandom_range(32'hFFFF, 32'h800);
            3: return $urandom_range(32'hDFFF, 32'hD800);
            4, 5: return $urandom_range(32'h10_FFFF, 32'h1_0000);
            6:
            begin
                base = edge_points[$urandom_range(edge_points.size() - 1)];
                return base + $urandom_range(2) - 1;
            end
            7: return $urandom_range(32'hFFFF_FFFF, 32'h11_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_OUTPUT_FORMAT: fmt_model = val;
            REG_STRICT_MODE:   strict_model = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_code_points.size() != 0 || in_valid || expected_units.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    // driver: offers pending code points, predicts each one at acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            code_point <= 32'h0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                encode_code_point(code_point);
                accepted_count++;
            end
            if (in_valid && !in_ready)
                input_stalls++;
            if (!in_valid || in_ready)
            begin
                if (pending_code_points.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid   <= 1'b1;
                    code_point <= pending_code_points.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each unit against the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                units_checked++;
                if (expected_units.size() == 0)
                    report_mismatch("unit with nothing pending", {16'h0, unit}, 32'h0);
                else
                begin
                    enc_unit_t want;
                    want = expected_units.pop_front();
                    if (unit !== want.unit)
                        report_mismatch("unit", {16'h0, unit}, {16'h0, want.unit});
                    if (last !== want.last)
                        report_mismatch("last", {31'h0, last}, {31'h0, want.last});
                    if (error !== want.err)
                        report_mismatch("error", {31'h0, error}, {31'h0, want.err});
                end
            end
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the queue inside the block fills up
    initial
    begin : receiver_hold
        wait (pressure_go);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("codepoint_to_utf8_utf16_encoder: mismatch");
            $finish;
        end
    end

    initial
    begin
        int sender_pct [4];
        int receiver_pct [4];
        int setting;
        int idle_mode;
        sender_pct   = '{0, 63, 0, 25};
        receiver_pct = '{0, 0, 63, 25};
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        code_point   = 32'h0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_OUTPUT_FORMAT;
        cfg_data     = 1'b0;
        recv_hold    = 1'b0;
        pressure_go  = 1'b0;
        fmt_model    = FMT_UTF8;
        strict_model = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        accepted_count = 0;
        units_checked  = 0;
        invalid_count  = 0;
        input_stalls   = 0;
        cycle_count    = 0;
        edge_points = '{32'h0000_0000, 32'h0000_007F, 32'h0000_0080, 32'h0000_07FF,
                        32'h0000_0800, 32'h0000_D800, 32'h0000_DFFF, 32'h0000_E000,
                        32'h0000_FFFF, 32'h0001_0000, 32'h0010_FFFF, 32'h0011_0000,
                        32'hFFFF_FFFF};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        // spare indexes must leave the reset settings alone
        write_reg(REG_SPARE_A, 1'b1);
        write_reg(REG_SPARE_B, 1'b1);
        foreach (edge_points[i])
            pending_code_points.push_back(edge_points[i]);
        wait_idle();

        write_reg(REG_OUTPUT_FORMAT, FMT_UTF16);
        write_reg(REG_STRICT_MODE, 1'b1);
        foreach (edge_points[i])
            pending_code_points.push_back(edge_points[i]);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            setting   = p % 4;
            idle_mode = (p + p / 4) % 4;
            write_reg(REG_OUTPUT_FORMAT, setting[1] ? FMT_UTF16 : FMT_UTF8);
            write_reg(REG_STRICT_MODE, setting[0]);
            send_idle_pct  = sender_pct[idle_mode];
            recv_stall_pct = receiver_pct[idle_mode];
            if (p == RAND_PHASES - 1)
                pressure_go = 1'b1;
            repeat (PHASE_ITEMS)
                pending_code_points.push_back(random_code_point());
            wait_idle();
        end

        $display("covered %0d code points as %0d units, %0d of them invalid",
                 accepted_count, units_checked, invalid_count);
        $display("both formats in replace and strict mode, input held off for %0d cycles",
                 input_stalls);
        if (mismatch_count == 0)
            $display("codepoint_to_utf8_utf16_encoder: match");
        else
            $display("codepoint_to_utf8_utf16_encoder: mismatch");
        $finish;
    end

endmodule
